>>> rtl/core/page_access_histogram_unit_macros.svh
// assertion macros for the page access histogram unit
// used by page_access_histogram_unit.sv, no other dependencies
`ifndef PAGE_ACCESS_HISTOGRAM_UNIT_MACROS_SVH
`define PAGE_ACCESS_HISTOGRAM_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PAH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("page access histogram check failed");
`define PAH_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("page access histogram check failed");
`else
`define PAH_ASSERT(lbl, clk, rst_n, prop)
`define PAH_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> rtl/core/pah_pkg.sv
// shared types and constants for the page access histogram unit
// no dependencies
`default_nettype none

package pah_pkg;

    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int DEF_COUNT_BITS    = 32;

    localparam int ADDR_W   = 64;
    localparam int INDEX_W  = 6;
    localparam int ACCESS_W = 32;
    localparam int SHIFT_W  = 6;

    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET = 6'd12;

    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 96;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_PAGE_SHIFT = 1'b0;

    typedef enum logic {
        ACT_RECORD = 1'b0,
        ACT_READ   = 1'b1
    } pah_action_t;

    typedef struct packed {
        logic               fire;
        pah_action_t        action;
        logic [ADDR_W-1:0]  base;
        logic [INDEX_W-1:0] index;
    } pah_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   page_base;
        logic [ACCESS_W-1:0] access_count;
        logic                entry_valid;
        logic                dropped;
    } pah_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/page_access_histogram_unit.sv
// page access histogram unit
// throughput one transaction per cycle while m_tready does not stall, set by the single-pass tag compare stage
// input register, then compare/update and result register; m_tready stalls both
// reset (aresetn low, synchronous) empties the table by clearing its fill count,
// sets page_shift to 12 and drops both valid registers; no clearing pass
// depends on pah_pkg, pah_cfg_regs, pah_table and the assertion macro header
`default_nettype none

`include "page_access_histogram_unit_macros.svh"

module page_access_histogram_unit import pah_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // address[63:0], entry_index[69:64], zero pad
    input  wire logic                  s_tuser,   // action
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,   // page_base[63:0], access_count[95:64]
    output logic      [M_TUSER_W-1:0]  m_tuser,   // entry_valid[0], dropped[1]
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

    // input register stage
    logic               in_valid_reg;
    logic               in_valid_next;
    pah_action_t        in_action_reg;
    logic [ADDR_W-1:0]  in_addr_reg;
    logic [INDEX_W-1:0] in_index_reg;

    // result register stage
    logic               out_valid_reg;
    logic               out_valid_next;
    pah_rsp_t           out_rsp_reg;

    logic               s_fire;
    logic               advance;
    logic [SHIFT_W-1:0] page_shift;
    logic [ADDR_W-1:0]  page_base;
    pah_req_t           tbl_req;
    pah_rsp_t           tbl_rsp;
    logic [FILL_W-1:0]  fill_cnt;

    pah_cfg_regs u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .page_shift (page_shift)
    );

    // item moves from input register into the result register when that one frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_action_reg <= pah_action_t'(s_tuser);
            in_addr_reg   <= s_tdata[ADDR_W-1:0];
            in_index_reg  <= s_tdata[ADDR_W +: INDEX_W];
        end
        if (advance) begin
            out_rsp_reg <= tbl_rsp;
        end
    end

    // clear the low page_shift bits to get the page base
    assign page_base = in_addr_reg & ({ADDR_W{1'b1}} << page_shift);

    always_comb begin
        tbl_req        = '0;
        tbl_req.fire   = advance;
        tbl_req.action = in_action_reg;
        tbl_req.base   = page_base;
        tbl_req.index  = in_index_reg;
    end

    pah_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (tbl_req),
        .rsp      (tbl_rsp),
        .fill_cnt (fill_cnt)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_rsp_reg.access_count, out_rsp_reg.page_base};
    assign m_tuser  = {out_rsp_reg.dropped, out_rsp_reg.entry_valid};

    // fill count never passes the table size
    `PAH_ASSERT(a_fill_bound, aclk, aresetn, 32'(fill_cnt) <= TABLE_ENTRIES)
    // table only grows when an item passes through the compare stage
    `PAH_ASSERT(a_fill_only_on_advance, aclk, aresetn, !advance |=> fill_cnt == $past(fill_cnt))
    // a dropped page means the table was already full
    `PAH_ASSERT(a_drop_when_full, aclk, aresetn, (m_tvalid && m_tuser[1]) |-> (32'(fill_cnt) == TABLE_ENTRIES))
    // nothing is valid in either stage right after reset
    `PAH_ASSERT_ALWAYS(a_reset_empty, aclk, $past(!aresetn) |-> (!in_valid_reg && !out_valid_reg))

endmodule

`default_nettype wire

>>> rtl/core/pah_cfg_regs.sv
// apb configuration register block (page_shift)
// depends on pah_pkg
`default_nettype none

module pah_cfg_regs import pah_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [SHIFT_W-1:0]    page_shift
);

    logic [SHIFT_W-1:0] page_shift_reg;
    logic [SHIFT_W-1:0] page_shift_next;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        page_shift_next = page_shift_reg;
        if (wr_en && (paddr[2] == REG_PAGE_SHIFT)) begin
            page_shift_next = pwdata[SHIFT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_shift_reg <= PAGE_SHIFT_RESET;
        end else begin
            page_shift_reg <= page_shift_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_PAGE_SHIFT) begin
            prdata = CFG_DATA_W'(page_shift_reg);
        end
    end

    assign page_shift = page_shift_reg;

endmodule

`default_nettype wire

>>> rtl/core/pah_table.sv
// page table: tag cells with parallel compare, counts, fill count
// depends on pah_pkg
`default_nettype none

module pah_table import pah_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int COUNT_BITS    = DEF_COUNT_BITS,
    localparam int FILL_W       = $clog2(TABLE_ENTRIES + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire pah_req_t          req,
    output pah_rsp_t               rsp,
    output logic      [FILL_W-1:0] fill_cnt
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(TABLE_ENTRIES);

    logic [ADDR_W-1:0]     tag_reg [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] cnt_reg [TABLE_ENTRIES];
    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_next;

    logic [TABLE_ENTRIES-1:0] hit;
    logic                     hit_any;
    logic [COUNT_BITS-1:0]    hit_cnt;
    logic [COUNT_BITS-1:0]    hit_cnt_inc;
    logic                     full;
    logic                     do_record;
    logic                     do_alloc;
    logic [IDX_W-1:0]         alloc_idx;
    logic [IDX_W-1:0]         rd_idx;
    logic                     rd_ok;

    // each cell compares its own tag; only filled cells take part
    always_comb begin
        hit     = '0;
        hit_cnt = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit[i]  = (FILL_W'(i) < fill_reg) && (tag_reg[i] == req.base);
            hit_cnt = hit_cnt | (hit[i] ? cnt_reg[i] : '0);
        end
    end

    assign hit_any     = |hit;
    assign hit_cnt_inc = (hit_cnt == '1) ? hit_cnt : hit_cnt + 1'b1;
    assign full        = (fill_reg == FULL_CNT);
    assign do_record   = req.fire && (req.action == ACT_RECORD);
    assign do_alloc    = do_record && !hit_any && !full;
    assign alloc_idx   = fill_reg[IDX_W-1:0];
    assign rd_idx      = IDX_W'(req.index);
    // entries fill in order, so index below fill count means in range and used
    assign rd_ok       = (32'(req.index) < 32'(fill_reg));

    always_comb begin
        fill_next = fill_reg;
        if (do_alloc) begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (do_record && hit[i]) begin
                cnt_reg[i] <= hit_cnt_inc;
            end else if (do_alloc && (alloc_idx == IDX_W'(i))) begin
                tag_reg[i] <= req.base;
                cnt_reg[i] <= COUNT_BITS'(1);
            end
        end
    end

    always_comb begin
        rsp = '0;
        unique case (req.action)
            ACT_RECORD: begin
                rsp.page_base = req.base;
                if (hit_any) begin
                    rsp.access_count = ACCESS_W'(hit_cnt_inc);
                    rsp.entry_valid  = 1'b1;
                end else if (!full) begin
                    rsp.access_count = ACCESS_W'(1);
                    rsp.entry_valid  = 1'b1;
                end else begin
                    rsp.dropped = 1'b1;
                end
            end
            ACT_READ: begin
                if (rd_ok) begin
                    rsp.page_base    = tag_reg[rd_idx];
                    rsp.access_count = ACCESS_W'(cnt_reg[rd_idx]);
                    rsp.entry_valid  = 1'b1;
                end
            end
            default: rsp = '0;
        endcase
    end

    assign fill_cnt = fill_reg;

endmodule

`default_nettype wire
